// ===== rtl/core/qvr_pkg.sv =====
package qvr_pkg;

    localparam int COMPONENT_WIDTH = 16;

endpackage

// ===== rtl/core/qvr_sqrt.sv =====
module qvr_sqrt
    import qvr_pkg::*;
#(
    parameter int CW     = COMPONENT_WIDTH,
    parameter int SIDE_W = 8
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*CW:0]       in_s,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [CW+15:0]      out_root,
    output logic [SIDE_W-1:0]   out_side
);

    localparam int DW = CW + 16;
    localparam int NB = 2 * DW;
    localparam int RW = DW + 2;

    logic [NB-1:0]     n_reg     [DW+1];
    logic [RW-1:0]     rem_reg   [DW+1];
    logic [DW-1:0]     root_reg  [DW+1];
    logic [SIDE_W-1:0] side_reg  [DW+1];
    logic              valid_reg [DW+1];

    always_comb
    begin
        n_reg[0]     = NB'({in_s, 30'd0});
        rem_reg[0]   = '0;
        root_reg[0]  = '0;
        side_reg[0]  = in_side;
        valid_reg[0] = in_valid;
    end

    for (genvar k = 0; k < DW; k++)
    begin : g_step
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] trial;
        logic          ge;

        always_comb
        begin
            rem_sh = {rem_reg[k][RW-3:0], n_reg[k][NB-1 -: 2]};
            trial  = {root_reg[k], 2'b01};
            ge     = rem_sh >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[k+1]    <= {n_reg[k][NB-3:0], 2'b00};
                rem_reg[k+1]  <= ge ? (rem_sh - trial) : rem_sh;
                root_reg[k+1] <= {root_reg[k][DW-2:0], ge};
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[DW];
    assign out_root  = root_reg[DW];
    assign out_side  = side_reg[DW];

endmodule

// ===== rtl/core/qvr_div.sv =====
module qvr_div
    import qvr_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [3*CW+4:0] p_x,
    input  logic signed [3*CW+4:0] p_y,
    input  logic signed [3*CW+4:0] p_z,
    input  logic [CW+15:0]       d,
    input  logic                 zq,
    output logic                 out_valid,
    output logic signed [CW-1:0] rot_x,
    output logic signed [CW-1:0] rot_y,
    output logic signed [CW-1:0] rot_z,
    output logic                 zero_quaternion,
    output logic                 saturated
);

    localparam int PW = 3 * CW + 5;
    localparam int DW = CW + 16;
    localparam int NW = (PW + 3 > DW + CW + 1) ? PW + 3 : DW + CW + 1;

    logic [PW-1:0] p_in [3];
    logic [PW-1:0] mag  [3];

    logic [NW-1:0] a_n_reg   [3];
    logic          a_neg_reg [3];
    logic [NW-1:0] a_den_reg;
    logic          a_zq_reg;
    logic          a_valid_reg;

    logic [NW-1:0] rem_reg   [CW+1][3];
    logic [CW-1:0] q_reg     [CW+1][3];
    logic          neg_reg   [CW+1][3];
    logic          ovf_reg   [CW+1][3];
    logic [NW-1:0] den_reg   [CW+1];
    logic          zq_reg    [CW+1];
    logic          valid_reg [CW+1];

    logic signed [CW-1:0] res      [3];
    logic                 lane_sat [3];

    logic                 o_valid_reg;
    logic signed [CW-1:0] o_rot_reg [3];
    logic                 o_zq_reg;
    logic                 o_sat_reg;

    always_comb
    begin
        p_in[0] = p_x;
        p_in[1] = p_y;
        p_in[2] = p_z;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = p_in[i][PW-1] ? (PW'(0) - p_in[i]) : p_in[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg  <= in_valid;
            valid_reg[0] <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                a_n_reg[i]      <= (NW'(mag[i]) << 2) + NW'(d);
                a_neg_reg[i]    <= p_in[i][PW-1];
                rem_reg[0][i]   <= a_n_reg[i];
                q_reg[0][i]     <= '0;
                neg_reg[0][i]   <= a_neg_reg[i];
                ovf_reg[0][i]   <= a_n_reg[i] >= (a_den_reg << CW);
            end
            a_den_reg  <= NW'(d) << 1;
            a_zq_reg   <= zq;
            den_reg[0] <= a_den_reg;
            zq_reg[0]  <= a_zq_reg;
        end
    end

    for (genvar k = 0; k < CW; k++)
    begin : g_step
        localparam int BIT = CW - 1 - k;
        logic [NW-1:0] dsh;
        logic          ge [3];

        always_comb
        begin
            dsh = den_reg[k] << BIT;
            for (int i = 0; i < 3; i++)
            begin
                ge[i] = rem_reg[k][i] >= dsh;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[k+1][i] <= ge[i] ? (rem_reg[k][i] - dsh) : rem_reg[k][i];
                    q_reg[k+1][i]   <= {q_reg[k][i][CW-2:0], ge[i]};
                    neg_reg[k+1][i] <= neg_reg[k][i];
                    ovf_reg[k+1][i] <= ovf_reg[k][i];
                end
                den_reg[k+1] <= den_reg[k];
                zq_reg[k+1]  <= zq_reg[k];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (neg_reg[CW][i])
            begin
                lane_sat[i] = ovf_reg[CW][i] ||
                              (q_reg[CW][i][CW-1] && (q_reg[CW][i][CW-2:0] != '0));
                res[i]      = lane_sat[i] ? {1'b1, {(CW-1){1'b0}}}
                                          : (CW'(0) - q_reg[CW][i]);
            end
            else
            begin
                lane_sat[i] = ovf_reg[CW][i] || q_reg[CW][i][CW-1];
                res[i]      = lane_sat[i] ? {1'b0, {(CW-1){1'b1}}} : q_reg[CW][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            o_valid_reg <= valid_reg[CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o_rot_reg[i] <= zq_reg[CW] ? '0 : res[i];
            end
            o_zq_reg  <= zq_reg[CW];
            o_sat_reg <= !zq_reg[CW] && (lane_sat[0] || lane_sat[1] || lane_sat[2]);
        end
    end

    assign out_valid       = o_valid_reg;
    assign rot_x           = o_rot_reg[0];
    assign rot_y           = o_rot_reg[1];
    assign rot_z           = o_rot_reg[2];
    assign zero_quaternion = o_zq_reg;
    assign saturated       = o_sat_reg;

endmodule

// ===== rtl/core/quaternion_vector_rotate.sv =====
// Quaternion vector rotation, fixed point.
// Input channel: in_valid / in_stall with quaternion quat_x/y/z/w (Q2.14)
// and vector vec_x/y/z (Q8.8). A transaction completes on a rising edge
// with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with rot_x/y/z (Q8.8, saturated),
// zero_quaternion and saturated. One result per input transaction, in order.
// Throughput: one transaction per cycle while out_stall does not hold a result.
// Pipeline, in order: a product stage, a sum stage, a second product stage
// and a second sum stage, one square-root stage per root bit
// (COMPONENT_WIDTH+16), then two setup stages, one divider stage per
// quotient bit and the output register.
// The whole pipeline moves as one; when out_stall holds a valid result,
// every stage holds and in_stall is raised in the same cycle. Empty
// stages are not squeezed out.
// Reset clears all valid bits; the pipeline comes up empty and ready.
module quaternion_vector_rotate
    import qvr_pkg::*;
#(
    parameter int CW = COMPONENT_WIDTH
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [CW-1:0] quat_x,
    input  logic signed [CW-1:0] quat_y,
    input  logic signed [CW-1:0] quat_z,
    input  logic signed [CW-1:0] quat_w,
    input  logic signed [CW-1:0] vec_x,
    input  logic signed [CW-1:0] vec_y,
    input  logic signed [CW-1:0] vec_z,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [CW-1:0] rot_x,
    output logic signed [CW-1:0] rot_y,
    output logic signed [CW-1:0] rot_z,
    output logic                 zero_quaternion,
    output logic                 saturated
);

    localparam int MW  = 2 * CW;
    localparam int TW  = 2 * CW + 2;
    localparam int CCW = CW + 1;
    localparam int XW  = TW + CCW;
    localparam int PW  = 3 * CW + 5;
    localparam int SW  = 2 * CW + 1;
    localparam int DW  = CW + 16;
    localparam int SIDE_W = 3 * PW + 1;

    logic en;

    logic signed [MW-1:0] wvx_reg, wvy_reg, wvz_reg;
    logic signed [MW-1:0] xvx_reg, xvy_reg, xvz_reg;
    logic signed [MW-1:0] yvx_reg, yvy_reg, yvz_reg;
    logic signed [MW-1:0] zvx_reg, zvy_reg, zvz_reg;
    logic signed [MW-1:0] xx_reg, yy_reg, zz_reg, ww_reg;
    logic signed [CCW-1:0] c1x_reg, c1y_reg, c1z_reg, c1w_reg;
    logic                  v1_reg;

    logic signed [TW-1:0]  tx_reg, ty_reg, tz_reg, tw_reg;
    logic signed [CCW-1:0] cx_reg, cy_reg, cz_reg, cw_reg;
    logic [SW-1:0]         s2_reg;
    logic                  zq2_reg;
    logic                  v2_reg;
    logic [SW-1:0]         s_next;

    logic signed [XW-1:0]  pxa_reg, pxb_reg, pxc_reg, pxd_reg;
    logic signed [XW-1:0]  pya_reg, pyb_reg, pyc_reg, pyd_reg;
    logic signed [XW-1:0]  pza_reg, pzb_reg, pzc_reg, pzd_reg;
    logic [SW-1:0]         s3_reg;
    logic                  zq3_reg;
    logic                  v3_reg;

    logic signed [PW-1:0]  px_reg, py_reg, pz_reg;
    logic [SW-1:0]         s4_reg;
    logic                  zq4_reg;
    logic                  v4_reg;

    logic                  sq_valid;
    logic [DW-1:0]         sq_root;
    logic [SIDE_W-1:0]     sq_side;

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        s_next = SW'(xx_reg) + SW'(yy_reg) + SW'(zz_reg) + SW'(ww_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wvx_reg <= quat_w * vec_x;
            wvy_reg <= quat_w * vec_y;
            wvz_reg <= quat_w * vec_z;
            xvx_reg <= quat_x * vec_x;
            xvy_reg <= quat_x * vec_y;
            xvz_reg <= quat_x * vec_z;
            yvx_reg <= quat_y * vec_x;
            yvy_reg <= quat_y * vec_y;
            yvz_reg <= quat_y * vec_z;
            zvx_reg <= quat_z * vec_x;
            zvy_reg <= quat_z * vec_y;
            zvz_reg <= quat_z * vec_z;
            xx_reg  <= quat_x * quat_x;
            yy_reg  <= quat_y * quat_y;
            zz_reg  <= quat_z * quat_z;
            ww_reg  <= quat_w * quat_w;
            c1x_reg <= CCW'(0) - CCW'(quat_x);
            c1y_reg <= CCW'(0) - CCW'(quat_y);
            c1z_reg <= CCW'(0) - CCW'(quat_z);
            c1w_reg <= CCW'(quat_w);

            tx_reg  <= TW'(wvx_reg) + TW'(yvz_reg) - TW'(zvy_reg);
            ty_reg  <= TW'(wvy_reg) + TW'(zvx_reg) - TW'(xvz_reg);
            tz_reg  <= TW'(wvz_reg) + TW'(xvy_reg) - TW'(yvx_reg);
            tw_reg  <= TW'(0) - TW'(xvx_reg) - TW'(yvy_reg) - TW'(zvz_reg);
            cx_reg  <= c1x_reg;
            cy_reg  <= c1y_reg;
            cz_reg  <= c1z_reg;
            cw_reg  <= c1w_reg;
            s2_reg  <= s_next;
            zq2_reg <= s_next == '0;

            pxa_reg <= tx_reg * cw_reg;
            pxb_reg <= tw_reg * cx_reg;
            pxc_reg <= ty_reg * cz_reg;
            pxd_reg <= tz_reg * cy_reg;
            pya_reg <= ty_reg * cw_reg;
            pyb_reg <= tw_reg * cy_reg;
            pyc_reg <= tz_reg * cx_reg;
            pyd_reg <= tx_reg * cz_reg;
            pza_reg <= tz_reg * cw_reg;
            pzb_reg <= tw_reg * cz_reg;
            pzc_reg <= tx_reg * cy_reg;
            pzd_reg <= ty_reg * cx_reg;
            s3_reg  <= s2_reg;
            zq3_reg <= zq2_reg;

            px_reg  <= PW'(pxa_reg) + PW'(pxb_reg) + PW'(pxc_reg) - PW'(pxd_reg);
            py_reg  <= PW'(pya_reg) + PW'(pyb_reg) + PW'(pyc_reg) - PW'(pyd_reg);
            pz_reg  <= PW'(pza_reg) + PW'(pzb_reg) + PW'(pzc_reg) - PW'(pzd_reg);
            s4_reg  <= s3_reg;
            zq4_reg <= zq3_reg;
        end
    end

    qvr_sqrt #(
        .CW     (CW),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_s      (s4_reg),
        .in_side   ({zq4_reg, px_reg, py_reg, pz_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    qvr_div #(
        .CW (CW)
    ) u_div (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (sq_valid),
        .p_x             (sq_side[3*PW-1:2*PW]),
        .p_y             (sq_side[2*PW-1:PW]),
        .p_z             (sq_side[PW-1:0]),
        .d               (sq_root),
        .zq              (sq_side[3*PW]),
        .out_valid       (out_valid),
        .rot_x           (rot_x),
        .rot_y           (rot_y),
        .rot_z           (rot_z),
        .zero_quaternion (zero_quaternion),
        .saturated       (saturated)
    );

endmodule
